>>> rtl/assert_macros.svh
// assertion macros included by the coalescer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define AST_IMP(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, checked out of reset
`define AST_NEXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/pkbc_pkg.sv
// shared types and constants of the per-key batch coalescer
`timescale 1ns / 1ps

package pkbc_pkg;

	localparam int KEY_W    = 32;
	localparam int DATA_W   = 64;
	localparam int BUCKET_W = 48;
	localparam int CFG_W    = 5;
	localparam int TDATA_W  = KEY_W + DATA_W + BUCKET_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_FILL,
		ST_APPEND,
		ST_EMIT_RD,
		ST_EMIT_LD
	} pkbc_state_t;

	// key search status back to the sequencer
	typedef struct packed {
		logic done;
		logic hit;
	} kt_status_t;

endpackage

>>> rtl/pkbc_key_table.sv
// key table memory with a sequential compare unit that scans used entries
`timescale 1ns / 1ps

module pkbc_key_table #(
	parameter int NUM_KEYS = 64,
	parameter int IDXW     = 6,
	parameter int CNTW     = 7
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [pkbc_pkg::KEY_W-1:0] key,
	input  logic [CNTW-1:0]        used,
	input  logic                   we,
	input  logic [IDXW-1:0]        waddr,
	input  logic [pkbc_pkg::KEY_W-1:0] wdata,
	output pkbc_pkg::kt_status_t   status,
	output logic [IDXW-1:0]        slot
);
	import pkbc_pkg::*;

	logic [KEY_W-1:0] mem [NUM_KEYS];

	logic            busy_q;
	logic [CNTW-1:0] rd_idx_q;
	logic            cmp_vld_s1;
	logic [IDXW-1:0] cmp_idx_s1;
	logic [KEY_W-1:0] rd_key_s1;

	logic match;
	logic done;
	logic issue;

	assign match = cmp_vld_s1 && (rd_key_s1 == key);
	assign done  = busy_q && (match || (!cmp_vld_s1 && (rd_idx_q >= used)));
	assign issue = busy_q && !done && (rd_idx_q < used);

	assign status.done = done;
	assign status.hit  = match;
	assign slot        = cmp_idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
		end else if (start) begin
			busy_q     <= 1'b1;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
		end else if (done) begin
			busy_q     <= 1'b0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= issue;
			if (issue) begin
				rd_idx_q <= rd_idx_q + CNTW'(1);
			end
		end
	end

	// one entry read per cycle, compared the cycle after
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_key_s1  <= mem[rd_idx_q[IDXW-1:0]];
			cmp_idx_s1 <= rd_idx_q[IDXW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

>>> rtl/pkbc_batch_store.sv
// per-entry fill counts and the buffered value memory
`timescale 1ns / 1ps

module pkbc_batch_store #(
	parameter int NUM_KEYS  = 64,
	parameter int MAX_BATCH = 16,
	parameter int IDXW      = 6,
	parameter int FILLW     = 4,
	parameter int VADDRW    = 10
) (
	input  logic                    clk,
	input  logic                    fill_we,
	input  logic [IDXW-1:0]         fill_waddr,
	input  logic [FILLW-1:0]        fill_wdata,
	input  logic                    fill_re,
	input  logic [IDXW-1:0]         fill_raddr,
	output logic [FILLW-1:0]        fill_rdata,
	input  logic                    val_we,
	input  logic                    val_re,
	input  logic [IDXW-1:0]         val_slot,
	input  logic [FILLW-1:0]        val_pos,
	input  logic [pkbc_pkg::DATA_W-1:0] val_wdata,
	output logic [pkbc_pkg::DATA_W-1:0] val_rdata
);
	import pkbc_pkg::*;

	localparam int VAW1  = VADDRW + 1;
	localparam int DEPTH = NUM_KEYS * MAX_BATCH;

	logic [FILLW-1:0]  fill_mem [NUM_KEYS];
	logic [DATA_W-1:0] val_mem  [DEPTH];

	logic [VAW1-1:0]   addr_full;
	logic [VADDRW-1:0] vaddr;

	// entry base is slot times the per-entry depth
	assign addr_full = VAW1'(val_slot) * VAW1'(MAX_BATCH) + VAW1'(val_pos);
	assign vaddr     = addr_full[VADDRW-1:0];

	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[fill_waddr] <= fill_wdata;
		end
		if (fill_re) begin
			fill_rdata <= fill_mem[fill_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[vaddr] <= val_wdata;
		end
		if (val_re) begin
			val_rdata <= val_mem[vaddr];
		end
	end

endmodule

>>> rtl/per_key_batch_coalescer.sv
// per-key batch coalescer top level: sequencer, config register, output register
// an item passes lookup, where table entries are scanned one per cycle, then a fill
//   count read on a hit, then the append; a dropped item skips the append
// a releasing item then emits each word by a value memory read, then a load once the output is free
// throughput: one item at a time; the input is ready only while the sequencer is idle
// reset: arst_n clears the table count, batch_size to 1 and all handshake state
`timescale 1ns / 1ps

`include "assert_macros.svh"

module per_key_batch_coalescer #(
	parameter int NUM_KEYS  = 64,
	parameter int MAX_BATCH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// config write channel: batch_size
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [pkbc_pkg::CFG_W-1:0]  cfg_data,   // batch_size
	// input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [pkbc_pkg::TDATA_W-1:0] s_tdata,   // symbol_key, data_word, bucket_start
	// output stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [pkbc_pkg::TDATA_W-1:0] m_tdata,   // out_key, out_data, out_bucket
	output logic                        m_tlast     // last_of_batch
);
	import pkbc_pkg::*;

	localparam int IDXW   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int CNTW   = $clog2(NUM_KEYS + 1);
	localparam int FILLW  = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
	localparam int BCW    = $clog2(MAX_BATCH + 1);
	localparam int VADDRW = (NUM_KEYS * MAX_BATCH > 1) ? $clog2(NUM_KEYS * MAX_BATCH) : 1;

	// sequencer state and per-item registers
	pkbc_state_t state_q, state_d;

	logic [CFG_W-1:0]    batch_q;      // batch_size register
	logic [CNTW-1:0]     used_q;       // table entries taken so far
	logic [KEY_W-1:0]    key_q;
	logic [DATA_W-1:0]   data_q;
	logic [BUCKET_W-1:0] bucket_q;
	logic [BCW-1:0]      arity_q;      // clamped batch size for this item
	logic [IDXW-1:0]     slot_q;
	logic [FILLW-1:0]    fill_q;       // values held before the append
	logic [BCW-1:0]      count_q;      // words in the batch being released
	logic [FILLW-1:0]    emit_idx_q;

	// output register
	logic                m_tvalid_q;
	logic [TDATA_W-1:0]  m_tdata_q;
	logic                m_tlast_q;

	// handshakes
	logic s_accept;
	logic cfg_accept;
	logic out_free;

	// key table
	kt_status_t          kt_st;
	logic [IDXW-1:0]     kt_slot;
	logic                kt_start;
	logic                kt_we;
	logic                table_full;

	// batch store
	logic                fill_we;
	logic [FILLW-1:0]    fill_wdata;
	logic                fill_re;
	logic [FILLW-1:0]    fill_rdata;
	logic                val_we;
	logic                val_re;
	logic [DATA_W-1:0]   val_rdata;

	// datapath helpers
	logic [BCW-1:0]      new_fill;
	logic                release_now;
	logic                emit_last;
	logic                out_load;
	logic [BCW-1:0]      arity_in;

	assign cfg_ready  = 1'b1;
	assign cfg_accept = cfg_valid && cfg_ready;
	assign s_accept   = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;

	assign table_full  = (used_q == CNTW'(NUM_KEYS));
	assign new_fill    = BCW'(fill_q) + BCW'(1);
	assign release_now = (new_fill >= arity_q);
	assign emit_last   = ((BCW'(emit_idx_q) + BCW'(1)) == count_q);

	// zero counts as one, anything above the buffer depth as the depth
	always_comb begin
		if (batch_q == '0) begin
			arity_in = BCW'(1);
		end else if (32'(batch_q) > 32'(MAX_BATCH)) begin
			arity_in = BCW'(MAX_BATCH);
		end else begin
			arity_in = BCW'(batch_q);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (kt_st.done) begin
					if (kt_st.hit) begin
						state_d = ST_FILL;
					end else if (table_full) begin
						state_d = ST_IDLE;    // unseen key, no room: dropped
					end else begin
						state_d = ST_APPEND;
					end
				end
			end
			ST_FILL: begin
				state_d = ST_APPEND;
			end
			ST_APPEND: begin
				state_d = release_now ? ST_EMIT_RD : ST_IDLE;
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				if (out_free) begin
					state_d = emit_last ? ST_IDLE : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready   = 1'b0;
		kt_start   = 1'b0;
		kt_we      = 1'b0;
		fill_re    = 1'b0;
		fill_we    = 1'b0;
		fill_wdata = '0;
		val_we     = 1'b0;
		val_re     = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				kt_start = s_tvalid;
			end
			ST_LOOKUP: begin
				fill_re = kt_st.done && kt_st.hit;
				kt_we   = kt_st.done && !kt_st.hit && !table_full;
			end
			ST_APPEND: begin
				val_we     = 1'b1;
				fill_we    = 1'b1;
				fill_wdata = release_now ? '0 : FILLW'(new_fill);
			end
			ST_EMIT_RD: begin
				val_re = 1'b1;
			end
			ST_EMIT_LD: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			batch_q    <= CFG_W'(1);
			used_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_accept) begin
				batch_q <= cfg_data;
			end
			if (kt_we) begin
				used_q <= used_q + CNTW'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// per-item payload registers
	always_ff @(posedge clk) begin
		if (s_accept) begin
			key_q    <= s_tdata[KEY_W-1:0];
			data_q   <= s_tdata[KEY_W+DATA_W-1:KEY_W];
			bucket_q <= s_tdata[TDATA_W-1:KEY_W+DATA_W];
			arity_q  <= arity_in;
		end
		if (state_q == ST_LOOKUP && kt_st.done) begin
			if (kt_st.hit) begin
				slot_q <= kt_slot;
			end else begin
				slot_q <= used_q[IDXW-1:0];
				fill_q <= '0;            // fresh entry starts empty
			end
		end
		if (state_q == ST_FILL) begin
			fill_q <= fill_rdata;
		end
		if (state_q == ST_APPEND && release_now) begin
			count_q    <= new_fill;
			emit_idx_q <= '0;
		end
		if (out_load) begin
			m_tdata_q  <= {bucket_q, val_rdata, key_q};
			m_tlast_q  <= emit_last;
			emit_idx_q <= emit_idx_q + FILLW'(1);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	pkbc_key_table #(
		.NUM_KEYS (NUM_KEYS),
		.IDXW     (IDXW),
		.CNTW     (CNTW)
	) u_key_table (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (kt_start),
		.key    (key_q),
		.used   (used_q),
		.we     (kt_we),
		.waddr  (used_q[IDXW-1:0]),
		.wdata  (key_q),
		.status (kt_st),
		.slot   (kt_slot)
	);

	// value position in the entry is the fill count while appending, the emit index while draining
	pkbc_batch_store #(
		.NUM_KEYS  (NUM_KEYS),
		.MAX_BATCH (MAX_BATCH),
		.IDXW      (IDXW),
		.FILLW     (FILLW),
		.VADDRW    (VADDRW)
	) u_batch_store (
		.clk        (clk),
		.fill_we    (fill_we),
		.fill_waddr (slot_q),
		.fill_wdata (fill_wdata),
		.fill_re    (fill_re),
		.fill_raddr (kt_slot),
		.fill_rdata (fill_rdata),
		.val_we     (val_we),
		.val_re     (val_re),
		.val_slot   (slot_q),
		.val_pos    ((state_q == ST_APPEND) ? fill_q : emit_idx_q),
		.val_wdata  (data_q),
		.val_rdata  (val_rdata)
	);

	// checks
	`AST_IMP(a_used_bound, clk, arst_n, 1'b1, used_q <= CNTW'(NUM_KEYS))
	`AST_IMP(a_kt_done_in_lookup, clk, arst_n, kt_st.done, state_q == ST_LOOKUP)
	`AST_IMP(a_emit_in_range, clk, arst_n, state_q == ST_EMIT_RD, BCW'(emit_idx_q) < count_q)
	`AST_NEXT(a_last_ends_batch, clk, arst_n, out_load && emit_last, state_q == ST_IDLE)

endmodule
